/* sv/sbr_pkg.sv */
// Shared types, constants and helper functions for the system bus with reservations.
// Used by sbr_resv, the top level and the checker; depends on nothing.
package sbr_pkg;

    localparam int IN_W  = 72;
    localparam int OUT_W = 72;

    localparam int MAIN_AW    = 16;
    localparam int SCRATCH_AW = 13;
    localparam int ROM_AW     = 15;
    localparam int VIDEO_AW   = 12;
    localparam int CLR_AW     = (MAIN_AW > ROM_AW) ? MAIN_AW : ROM_AW;

    localparam int MAIN_WORDS    = 1 << MAIN_AW;
    localparam int SCRATCH_WORDS = 1 << SCRATCH_AW;
    localparam int ROM_WORDS     = 1 << ROM_AW;
    localparam int VIDEO_WORDS   = 1 << VIDEO_AW;

    localparam int NUM_BREAKPOINTS = 4;
    localparam int CFG_IDX_W       = 3;
    localparam int CNT_W           = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_BP_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BP_ADDR_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BP_ADDR_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BP_ADDR_C = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BP_ADDR_D = 3'd4;

    localparam int OUT_OK_BIT      = 32;
    localparam int OUT_ERR_BIT     = 33;
    localparam int OUT_STOP_BIT    = 34;
    localparam int OUT_REFRESH_BIT = 35;

    localparam logic [31:0] GEN_HIGH_INIT = 32'd88888888;
    localparam logic [31:0] GEN_LOW_INIT  = 32'd12345678;
    localparam logic [31:0] GEN_HIGH_MUL  = 32'd36969;
    localparam logic [31:0] GEN_LOW_MUL   = 32'd18000;

    localparam logic [3:0] MASK_NONE     = 4'h0;
    localparam logic [3:0] MASK_BYTE0    = 4'h1;
    localparam logic [3:0] MASK_BYTE1    = 4'h2;
    localparam logic [3:0] MASK_BYTE2    = 4'h4;
    localparam logic [3:0] MASK_BYTE3    = 4'h8;
    localparam logic [3:0] MASK_HALF_LO  = 4'h3;
    localparam logic [3:0] MASK_HALF_MID = 4'h6;
    localparam logic [3:0] MASK_HALF_HI  = 4'hC;
    localparam logic [3:0] MASK_WORD     = 4'hF;

    typedef enum logic [2:0] {
        REG_NONE,
        REG_MAIN,
        REG_SCRATCH,
        REG_LED,
        REG_ROM,
        REG_VIDEO
    } region_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic        fire;
        logic        rsv_read;
        logic        cond_write;
        logic [31:0] addr;
    } resv_req_t;

    function automatic region_t sbr_decode(input logic [31:0] a, input logic wr);
        region_t r;
        if (a[31:27] == 5'd0) begin
            r = REG_MAIN;
        end else if (a[31:20] == 12'hFF4) begin
            r = REG_SCRATCH;
        end else if (wr && (a[31:8] == 24'hFFDC06)) begin
            r = REG_LED;
        end else if (a[31:18] == 14'h3FFF) begin
            r = REG_ROM;
        end else if (a[31:16] == 16'hFFD0) begin
            r = REG_VIDEO;
        end else begin
            r = REG_NONE;
        end
        return r;
    endfunction

    function automatic logic [31:0] lane_merge(input logic [31:0] old,
                                               input logic [31:0] d,
                                               input logic [3:0]  mask);
        logic [31:0] r;
        case (mask)
            MASK_WORD:     r = d;
            MASK_BYTE0:    r = {old[31:8], d[7:0]};
            MASK_BYTE1:    r = {old[31:16], d[7:0], old[7:0]};
            MASK_BYTE2:    r = {old[31:24], d[7:0], old[15:0]};
            MASK_BYTE3:    r = {d[7:0], old[23:0]};
            MASK_HALF_LO:  r = {old[31:16], d[15:0]};
            MASK_HALF_MID: r = {old[31:24], d[15:0], old[7:0]};
            MASK_HALF_HI:  r = {d[15:0], old[15:0]};
            default:       r = old;
        endcase
        return r;
    endfunction

endpackage

/* sv/sbr_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; no package dependency.
module sbr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wen,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             ren,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (wen) begin
            mem[waddr] <= wdata;
        end
        if (ren) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/sbr_resv.sv */
// Reservation slots and multiply-with-carry replacement generator.
// Depends on sbr_pkg for the request struct and generator constants.
module sbr_resv (
    input  logic               aclk,
    input  logic               aresetn,
    input  sbr_pkg::resv_req_t req,
    output logic               match
);
    import sbr_pkg::*;

    logic [31:0] slot_one_reg, slot_one_next;
    logic [31:0] slot_two_reg, slot_two_next;
    logic        valid_one_reg, valid_one_next;
    logic        valid_two_reg, valid_two_next;
    logic [31:0] gen_high_reg, gen_high_next;
    logic [31:0] gen_low_reg, gen_low_next;
    logic [31:0] gen_high_step;
    logic [31:0] gen_low_step;
    logic        hit_one;
    logic        hit_two;

    assign hit_one = valid_one_reg && (slot_one_reg == req.addr);
    assign hit_two = valid_two_reg && (slot_two_reg == req.addr);
    assign match   = hit_one || hit_two;

    assign gen_high_step = GEN_HIGH_MUL * {16'd0, gen_high_reg[15:0]} + {16'd0, gen_high_reg[31:16]};
    assign gen_low_step  = GEN_LOW_MUL * {16'd0, gen_low_reg[15:0]} + {16'd0, gen_low_reg[31:16]};

    always_comb begin
        slot_one_next  = slot_one_reg;
        slot_two_next  = slot_two_reg;
        valid_one_next = valid_one_reg;
        valid_two_next = valid_two_reg;
        gen_high_next  = gen_high_reg;
        gen_low_next   = gen_low_reg;
        if (req.fire && req.rsv_read) begin
            if (!valid_one_reg) begin
                slot_one_next  = req.addr;
                valid_one_next = 1'b1;
            end else if (!valid_two_reg) begin
                slot_two_next  = req.addr;
                valid_two_next = 1'b1;
            end else begin
                gen_high_next = gen_high_step;
                gen_low_next  = gen_low_step;
                // bit 0 of (high << 16) + low is bit 0 of low
                if (gen_low_step[0]) begin
                    slot_two_next = req.addr;
                end else begin
                    slot_one_next = req.addr;
                end
            end
        end
        if (req.fire && req.cond_write) begin
            if (hit_one) begin
                valid_one_next = 1'b0;
            end
            if (hit_two) begin
                valid_two_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_one_reg  <= '0;
            slot_two_reg  <= '0;
            valid_one_reg <= 1'b0;
            valid_two_reg <= 1'b0;
            gen_high_reg  <= GEN_HIGH_INIT;
            gen_low_reg   <= GEN_LOW_INIT;
        end else begin
            slot_one_reg  <= slot_one_next;
            slot_two_reg  <= slot_two_next;
            valid_one_reg <= valid_one_next;
            valid_two_reg <= valid_two_next;
            gen_high_reg  <= gen_high_next;
            gen_low_reg   <= gen_low_next;
        end
    end

endmodule

/* sv/system_bus_with_reservations_top.sv */
// An accepted access is registered into the execute state, and its result into the output register.
// No new access is taken until that result is registered, as the stores are read then written back.
// Reset: synchronous, active low; afterwards a clearing pass over every store address
// zeroes all stores, with s_tready low. Configuration writes are taken throughout.
// Top level: address decode, store read-modify-write, breakpoints and sticky flags.
// Depends on sbr_pkg, sbr_ram and sbr_resv.
module system_bus_with_reservations_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wen,
    input  logic [sbr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // action[0], address[32:1], write_data[64:33], byte_mask[68:65], reserve[69],
    // conditional[70], zero pad[71]
    input  logic [sbr_pkg::IN_W-1:0]       s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // read_data[31:0], write_ok[32], error_sticky[33], stop_sticky[34],
    // refresh_sticky[35], led_value[67:36], zero pad[71:68]
    output logic [sbr_pkg::OUT_W-1:0]      m_tdata
);
    import sbr_pkg::*;

    state_t state_reg, state_next;
    logic [CLR_AW-1:0] clr_cnt_reg;
    logic clearing;
    logic accept;
    logic out_free;
    logic done;

    logic        st_wr_reg;
    logic [31:0] st_addr_reg;
    logic [31:0] st_data_reg;
    logic [3:0]  st_mask_reg;
    logic        st_rsv_reg;
    logic        st_cond_reg;

    logic [CNT_W-1:0] bp_count_reg;
    logic [31:0]      bp_addr_reg [NUM_BREAKPOINTS];
    logic [CNT_W-1:0] bp_limit;
    logic             bp_hit;

    logic        error_reg, error_next;
    logic        stop_reg, stop_next;
    logic        refresh_reg, refresh_next;
    logic [31:0] led_reg, led_next;
    logic        m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;

    logic [31:0] in_addr;
    region_t     region;
    logic        protect;
    logic        resv_match;
    logic        write_ok;
    logic        do_write;
    logic [31:0] read_data;
    logic [31:0] merge_data;
    resv_req_t   resv_req;

    logic        main_we, scratch_we, rom_we, video_we;
    logic [31:0] main_rd, scratch_rd, rom_rd, video_rd;
    logic [31:0] main_wd, scratch_wd, rom_wd, video_wd;

    assign in_addr  = s_tdata[32:1];
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (&clr_cnt_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        clearing = 1'b0;
        done     = 1'b0;
        case (state_reg)
            ST_CLEAR: clearing = 1'b1;
            ST_IDLE:  s_tready = 1'b1;
            ST_EXEC:  done     = out_free;
            default:  clearing = 1'b0;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (clearing) begin
                clr_cnt_reg <= clr_cnt_reg + CLR_AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_wr_reg   <= s_tdata[0];
            st_addr_reg <= s_tdata[32:1];
            st_data_reg <= s_tdata[64:33];
            st_mask_reg <= s_tdata[68:65];
            st_rsv_reg  <= s_tdata[69];
            st_cond_reg <= s_tdata[70];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bp_count_reg <= '0;
            for (int i = 0; i < NUM_BREAKPOINTS; i++) begin
                bp_addr_reg[i] <= '0;
            end
        end else if (cfg_wen) begin
            case (cfg_index)
                CFG_BP_COUNT:  bp_count_reg   <= cfg_wdata[CNT_W-1:0];
                CFG_BP_ADDR_A: bp_addr_reg[0] <= cfg_wdata;
                CFG_BP_ADDR_B: bp_addr_reg[1] <= cfg_wdata;
                CFG_BP_ADDR_C: bp_addr_reg[2] <= cfg_wdata;
                CFG_BP_ADDR_D: bp_addr_reg[3] <= cfg_wdata;
                default:       bp_count_reg   <= bp_count_reg;
            endcase
        end
    end

    assign bp_limit = (bp_count_reg > CNT_W'(NUM_BREAKPOINTS)) ?
                      CNT_W'(NUM_BREAKPOINTS) : bp_count_reg;

    always_comb begin
        bp_hit = 1'b0;
        for (int i = 0; i < NUM_BREAKPOINTS; i++) begin
            if ((CNT_W'(i) < bp_limit) && (bp_addr_reg[i] == st_addr_reg)) begin
                bp_hit = 1'b1;
            end
        end
    end

    assign region   = sbr_decode(st_addr_reg, st_wr_reg);
    assign protect  = (st_addr_reg[31:16] == 16'h0001);
    assign write_ok = !(st_wr_reg && st_cond_reg && !resv_match);
    assign do_write = done && st_wr_reg && write_ok;

    assign resv_req.fire       = done;
    assign resv_req.rsv_read   = !st_wr_reg && st_rsv_reg;
    assign resv_req.cond_write = st_wr_reg && st_cond_reg;
    assign resv_req.addr       = st_addr_reg;

    sbr_resv u_resv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (resv_req),
        .match   (resv_match)
    );

    always_comb begin
        merge_data = st_data_reg;
        case (region)
            REG_MAIN:    merge_data = lane_merge(main_rd, st_data_reg, st_mask_reg);
            REG_SCRATCH: merge_data = lane_merge(scratch_rd, st_data_reg, st_mask_reg);
            default:     merge_data = st_data_reg;
        endcase
    end

    always_comb begin
        read_data = '0;
        if (!st_wr_reg) begin
            case (region)
                REG_MAIN:    read_data = main_rd;
                REG_SCRATCH: read_data = scratch_rd;
                REG_ROM:     read_data = rom_rd;
                REG_VIDEO:   read_data = video_rd;
                default:     read_data = '0;
            endcase
        end
    end

    assign main_we    = clearing || (do_write && (region == REG_MAIN) && !protect);
    assign scratch_we = clearing || (do_write && (region == REG_SCRATCH));
    assign rom_we     = clearing || (do_write && (region == REG_ROM));
    assign video_we   = clearing || (do_write && (region == REG_VIDEO));
    assign main_wd    = clearing ? '0 : merge_data;
    assign scratch_wd = clearing ? '0 : merge_data;
    assign rom_wd     = clearing ? '0 : merge_data;
    assign video_wd   = clearing ? '0 : merge_data;

    sbr_ram #(.WIDTH(32), .DEPTH(MAIN_WORDS)) u_main (
        .aclk  (aclk),
        .wen   (main_we),
        .waddr (clearing ? clr_cnt_reg[MAIN_AW-1:0] : st_addr_reg[MAIN_AW+1:2]),
        .wdata (main_wd),
        .ren   (accept),
        .raddr (in_addr[MAIN_AW+1:2]),
        .rdata (main_rd)
    );

    sbr_ram #(.WIDTH(32), .DEPTH(SCRATCH_WORDS)) u_scratch (
        .aclk  (aclk),
        .wen   (scratch_we),
        .waddr (clearing ? clr_cnt_reg[SCRATCH_AW-1:0] : st_addr_reg[SCRATCH_AW+1:2]),
        .wdata (scratch_wd),
        .ren   (accept),
        .raddr (in_addr[SCRATCH_AW+1:2]),
        .rdata (scratch_rd)
    );

    sbr_ram #(.WIDTH(32), .DEPTH(ROM_WORDS)) u_rom (
        .aclk  (aclk),
        .wen   (rom_we),
        .waddr (clearing ? clr_cnt_reg[ROM_AW-1:0] : st_addr_reg[ROM_AW+1:2]),
        .wdata (rom_wd),
        .ren   (accept),
        .raddr (in_addr[ROM_AW+1:2]),
        .rdata (rom_rd)
    );

    sbr_ram #(.WIDTH(32), .DEPTH(VIDEO_WORDS)) u_video (
        .aclk  (aclk),
        .wen   (video_we),
        .waddr (clearing ? clr_cnt_reg[VIDEO_AW-1:0] : st_addr_reg[VIDEO_AW+1:2]),
        .wdata (video_wd),
        .ren   (accept),
        .raddr (in_addr[VIDEO_AW+1:2]),
        .rdata (video_rd)
    );

    assign error_next   = error_reg || (do_write && (region == REG_MAIN) && protect);
    assign stop_next    = stop_reg || (done && st_wr_reg && bp_hit);
    assign refresh_next = refresh_reg || (do_write && (region == REG_VIDEO));
    assign led_next     = (do_write && (region == REG_LED)) ? st_data_reg : led_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_reg    <= 1'b0;
            stop_reg     <= 1'b0;
            refresh_reg  <= 1'b1;
            led_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            error_reg   <= error_next;
            stop_reg    <= stop_next;
            refresh_reg <= refresh_next;
            led_reg     <= led_next;
            if (done) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            m_tdata_reg <= {4'd0, led_next, refresh_next, stop_next, error_next,
                            write_ok, read_data};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* sv/sbr_checker.sv */
// Port-level checker for the system bus with reservations, bound to the top level.
// Depends on sbr_pkg for field positions.
module sbr_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [sbr_pkg::OUT_W-1:0] m_tdata
);
    import sbr_pkg::*;

    logic out_xfer;
    logic err_seen_reg;
    logic stop_seen_reg;

    assign out_xfer = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_seen_reg  <= 1'b0;
            stop_seen_reg <= 1'b0;
        end else if (out_xfer) begin
            err_seen_reg  <= err_seen_reg || m_tdata[OUT_ERR_BIT];
            stop_seen_reg <= stop_seen_reg || m_tdata[OUT_STOP_BIT];
        end
    end

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while previous transfer in progress");

    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        out_xfer && err_seen_reg |-> m_tdata[OUT_ERR_BIT])
        else $error("error flag dropped");

    a_stop_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        out_xfer && stop_seen_reg |-> m_tdata[OUT_STOP_BIT])
        else $error("stop flag dropped");

endmodule

bind system_bus_with_reservations_top sbr_checker u_sbr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
